@@ sv/nca_pkg.sv @@
// Shared constants, codes and word types of the nearest-centroid assigner.
`timescale 1ns / 1ps
`default_nettype none

package nca_pkg;

    localparam int MAX_CLUSTERS  = 64;
    localparam int MAX_DIMS      = 16;
    localparam int FEATURE_WIDTH = 16;
    localparam int DIST_WIDTH    = 38;
    localparam int SQ_WIDTH      = 2 * FEATURE_WIDTH;

    localparam int CLUSTERS_WIDTH = 7;
    localparam int DIMS_WIDTH     = 5;
    localparam int CIDX_WIDTH     = 6;
    localparam int DIDX_WIDTH     = 4;
    localparam int PREV_WIDTH     = 7;
    localparam int BEST_WIDTH     = 6;

    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    localparam logic [CLUSTERS_WIDTH-1:0] CLUSTERS_RESET = 7'd8;
    localparam logic [DIMS_WIDTH-1:0]     DIMS_RESET     = 5'd8;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    localparam logic REG_CLUSTERS = 1'b0;
    localparam logic REG_DIMS     = 1'b1;

    typedef struct packed {
        logic                             req_type;
        logic [CIDX_WIDTH-1:0]            centroid_index;
        logic [DIDX_WIDTH-1:0]            dim_index;
        logic signed [FEATURE_WIDTH-1:0]  coord_value;
        logic [PREV_WIDTH-1:0]            prev_cluster;
        logic                             last;
        logic [CLUSTERS_WIDTH-1:0]        clusters;
    } cmd_t;

    typedef struct packed {
        logic [BEST_WIDTH-1:0] best_cluster;
        logic [DIST_WIDTH-1:0] min_distance_sq;
        logic                  changed;
    } result_t;

endpackage

`default_nettype wire

@@ sv/nca_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module nca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/nca_fifo.sv @@
// Small register FIFO for command and result words.
`timescale 1ns / 1ps
`default_nettype none

module nca_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (32'(count_reg) == DEPTH);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (32'(wptr_reg) == DEPTH - 1) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (32'(rptr_reg) == DEPTH - 1) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ sv/nca_front.sv @@
// Front end: accept words, classify them and queue commands for the back end.
`timescale 1ns / 1ps
`default_nettype none

module nca_front #(
    parameter int MAX_CLUSTERS = nca_pkg::MAX_CLUSTERS,
    parameter int MAX_DIMS     = nca_pkg::MAX_DIMS
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic [nca_pkg::CLUSTERS_WIDTH-1:0]      active_clusters,
    input  wire logic [nca_pkg::DIMS_WIDTH-1:0]          active_dims,
    input  wire logic                                    push,
    output logic                                         full,
    input  wire logic                                    req_type,
    input  wire logic [nca_pkg::CIDX_WIDTH-1:0]          centroid_index,
    input  wire logic [nca_pkg::DIDX_WIDTH-1:0]          dim_index,
    input  wire logic signed [nca_pkg::FEATURE_WIDTH-1:0] coord_value,
    input  wire logic [nca_pkg::PREV_WIDTH-1:0]          prev_cluster,
    input  wire logic                                    cmd_pop,
    output logic                                         cmd_empty,
    output nca_pkg::cmd_t                                cmd
);

    localparam int CMD_W = $bits(nca_pkg::cmd_t);

    logic [nca_pkg::CLUSTERS_WIDTH-1:0] eff_clusters;
    logic [nca_pkg::DIMS_WIDTH-1:0]     eff_dims;
    logic                               keep;
    nca_pkg::cmd_t                      cmd_in;
    logic [CMD_W-1:0]                   cmd_rdata;

    always_comb
    begin
        if (active_clusters == '0)
        begin
            eff_clusters = nca_pkg::CLUSTERS_WIDTH'(1);
        end
        else if (32'(active_clusters) > MAX_CLUSTERS)
        begin
            eff_clusters = nca_pkg::CLUSTERS_WIDTH'(MAX_CLUSTERS);
        end
        else
        begin
            eff_clusters = active_clusters;
        end

        if (active_dims == '0)
        begin
            eff_dims = nca_pkg::DIMS_WIDTH'(1);
        end
        else if (32'(active_dims) > MAX_DIMS)
        begin
            eff_dims = nca_pkg::DIMS_WIDTH'(MAX_DIMS);
        end
        else
        begin
            eff_dims = active_dims;
        end
    end

    always_comb
    begin
        if (req_type == nca_pkg::REQ_LOAD)
        begin
            keep = (32'(centroid_index) < MAX_CLUSTERS) && (32'(dim_index) < MAX_DIMS);
        end
        else
        begin
            keep = (32'(dim_index) < 32'(eff_dims));
        end
        cmd_in.req_type       = req_type;
        cmd_in.centroid_index = centroid_index;
        cmd_in.dim_index      = dim_index;
        cmd_in.coord_value    = coord_value;
        cmd_in.prev_cluster   = prev_cluster;
        cmd_in.last           = (32'(dim_index) == 32'(eff_dims) - 1);
        cmd_in.clusters       = eff_clusters;
    end

    // drop ignored words at the door; full still reflects the queue
    nca_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (nca_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && keep),
        .wdata (CMD_W'(cmd_in)),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    assign cmd = nca_pkg::cmd_t'(cmd_rdata);

endmodule

`default_nettype wire

@@ sv/nca_back.sv @@
// Back end: centroid store writes and the per-cluster distance pipeline.
`timescale 1ns / 1ps
`default_nettype none

module nca_back #(
    parameter int MAX_CLUSTERS = nca_pkg::MAX_CLUSTERS,
    parameter int MAX_DIMS     = nca_pkg::MAX_DIMS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_empty,
    output logic                   cmd_pop,
    input  wire nca_pkg::cmd_t     cmd,
    input  wire logic              out_full,
    output logic                   out_push,
    output nca_pkg::result_t       out_word
);

    localparam int FW   = nca_pkg::FEATURE_WIDTH;
    localparam int DW   = nca_pkg::DIST_WIDTH;
    localparam int SW   = nca_pkg::SQ_WIDTH;
    localparam int CLW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CDEP = MAX_CLUSTERS * MAX_DIMS;
    localparam int CAW  = (CDEP > 1) ? $clog2(CDEP) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CLW-1:0]      c_reg, c_next;
    nca_pkg::cmd_t       cur_reg;
    logic                issue, issue_fin;

    logic                s1_v_reg, s1_fin_reg, s1_hit_reg;
    logic [CLW-1:0]      s1_c_reg;
    logic                s2_v_reg, s2_fin_reg;
    logic [CLW-1:0]      s2_c_reg;
    logic [FW-1:0]       s2_mag_reg;
    logic [DW-1:0]       s2_acc_reg;
    logic                s3_v_reg, s3_fin_reg;
    logic [CLW-1:0]      s3_c_reg;
    logic [SW-1:0]       s3_sq_reg;
    logic [DW-1:0]       s3_acc_reg;

    logic [MAX_CLUSTERS-1:0] acc_vld_reg;
    logic [DW-1:0]       best_d_reg;
    logic [CLW-1:0]      best_c_reg;

    logic                cram_we;
    logic [CAW-1:0]      cram_waddr, cram_raddr;
    logic [FW-1:0]       cram_rdata;
    logic [DW-1:0]       aram_rdata;

    logic signed [FW:0]  diff;
    logic [FW-1:0]       mag;
    logic [SW-1:0]       sq;
    logic [DW:0]         sum;
    logic [DW-1:0]       sat;
    logic                take;
    logic [DW-1:0]       res_d;
    logic [CLW-1:0]      res_c;

    // a point coordinate that ends a point needs room for its result
    assign cmd_pop = (state_reg == ST_IDLE) && !cmd_empty
                     && (cmd.req_type == nca_pkg::REQ_LOAD || !cmd.last || !out_full);
    assign cram_we    = cmd_pop && (cmd.req_type == nca_pkg::REQ_LOAD);
    assign cram_waddr = CAW'(32'(cmd.centroid_index) * MAX_DIMS + 32'(cmd.dim_index));
    assign cram_raddr = CAW'(32'(c_reg) * MAX_DIMS + 32'(cur_reg.dim_index));
    assign issue      = (state_reg == ST_RUN);
    assign issue_fin  = (32'(c_reg) == 32'(cur_reg.clusters) - 1);

    always_comb
    begin
        state_next = state_reg;
        c_next     = c_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_pop && cmd.req_type == nca_pkg::REQ_POINT)
                begin
                    state_next = ST_RUN;
                    c_next     = '0;
                end
            end
            ST_RUN:
            begin
                c_next = c_reg + 1'b1;
                if (issue_fin)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (s3_v_reg && s3_fin_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    nca_ram #(
        .WIDTH (FW),
        .DEPTH (CDEP)
    ) u_centroid_ram (
        .clk   (clk),
        .we    (cram_we),
        .waddr (cram_waddr),
        .wdata (cmd.coord_value),
        .re    (issue),
        .raddr (cram_raddr),
        .rdata (cram_rdata)
    );

    nca_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_CLUSTERS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (s3_v_reg),
        .waddr (s3_c_reg),
        .wdata (sat),
        .re    (issue),
        .raddr (c_reg),
        .rdata (aram_rdata)
    );

    always_comb
    begin
        diff  = $signed({cur_reg.coord_value[FW-1], cur_reg.coord_value})
                - $signed({cram_rdata[FW-1], cram_rdata});
        mag   = diff[FW] ? FW'(-diff) : FW'(diff);
        sq    = SW'(s2_mag_reg) * SW'(s2_mag_reg);
        sum   = {1'b0, s3_acc_reg} + (DW + 1)'(s3_sq_reg);
        sat   = sum[DW] ? '1 : sum[DW-1:0];
        take  = (s3_c_reg == '0) || (sat < best_d_reg);
        res_d = take ? sat : best_d_reg;
        res_c = take ? s3_c_reg : best_c_reg;
    end

    assign out_push                 = s3_v_reg && s3_fin_reg && cur_reg.last;
    assign out_word.best_cluster    = nca_pkg::BEST_WIDTH'(res_c);
    assign out_word.min_distance_sq = res_d;
    assign out_word.changed         = (32'(cur_reg.prev_cluster) != 32'(res_c));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            c_reg       <= '0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            acc_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            c_reg     <= c_next;
            s1_v_reg  <= issue;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            if (out_push)
            begin
                acc_vld_reg <= '0;
            end
            else if (s3_v_reg)
            begin
                acc_vld_reg[s3_c_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
        s1_c_reg   <= c_reg;
        s1_fin_reg <= issue_fin;
        s1_hit_reg <= acc_vld_reg[c_reg];
        s2_c_reg   <= s1_c_reg;
        s2_fin_reg <= s1_fin_reg;
        s2_mag_reg <= mag;
        s2_acc_reg <= s1_hit_reg ? aram_rdata : '0;
        s3_c_reg   <= s2_c_reg;
        s3_fin_reg <= s2_fin_reg;
        s3_sq_reg  <= sq;
        s3_acc_reg <= s2_acc_reg;
        if (s3_v_reg && cur_reg.last)
        begin
            best_d_reg <= res_d;
            best_c_reg <= res_c;
        end
    end

endmodule

`default_nettype wire

@@ sv/nearest_centroid_assigner.sv @@
// Top level of the nearest-centroid assigner: configuration port, front, back, result queue.
//
// K-means assignment step. A load word (req_type 0) writes one signed Q5.10 centroid
// coordinate into the centroid store while the back end stays idle. A point word
// (req_type 1) carries one coordinate of a point; the back end streams the K active
// centroids through a four-stage pipeline (store read, difference, square, saturating
// accumulate and compare), one cluster per cycle, and waits for the pipeline to drain
// before it pops another command from the queue. On the coordinate numbered
// active_dims - 1 the block queues the nearest cluster (lowest index on ties), its
// squared distance as unsigned Q18.20 saturating at 2^38 - 1, and whether it differs
// from prev_cluster (64 means unassigned). Loads with out-of-range indexes and point
// words at or beyond active_dims are dropped. A four-word command queue lets the input
// side run ahead of the back end. Centroid entries hold no reset value: reading one that
// was never loaded gives arbitrary results. Write the configuration registers
// (active_clusters at 0x0, active_dims at 0x4) only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module nearest_centroid_assigner #(
    parameter int MAX_CLUSTERS = nca_pkg::MAX_CLUSTERS,
    parameter int MAX_DIMS     = nca_pkg::MAX_DIMS
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic [nca_pkg::APB_ADDR_WIDTH-1:0]       paddr,
    input  wire logic [nca_pkg::APB_DATA_WIDTH-1:0]       pwdata,
    output logic      [nca_pkg::APB_DATA_WIDTH-1:0]       prdata,
    output logic                                          pready,
    input  wire logic                                     push,
    output logic                                          full,
    input  wire logic                                     req_type,
    input  wire logic [nca_pkg::CIDX_WIDTH-1:0]           centroid_index,
    input  wire logic [nca_pkg::DIDX_WIDTH-1:0]           dim_index,
    input  wire logic signed [nca_pkg::FEATURE_WIDTH-1:0] coord_value,
    input  wire logic [nca_pkg::PREV_WIDTH-1:0]           prev_cluster,
    output logic                                          empty,
    input  wire logic                                     pop,
    output logic      [nca_pkg::BEST_WIDTH-1:0]           best_cluster,
    output logic      [nca_pkg::DIST_WIDTH-1:0]           min_distance_sq,
    output logic                                          changed
);

    localparam int RES_W = $bits(nca_pkg::result_t);

    logic [nca_pkg::CLUSTERS_WIDTH-1:0] clusters_reg;
    logic [nca_pkg::DIMS_WIDTH-1:0]     dims_reg;
    logic                               cfg_we;
    logic                               cmd_pop, cmd_empty;
    nca_pkg::cmd_t                      cmd;
    logic                               out_full, out_push;
    nca_pkg::result_t                   out_word, res_word;
    logic [RES_W-1:0]                   res_rdata;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            nca_pkg::REG_CLUSTERS: prdata = nca_pkg::APB_DATA_WIDTH'(clusters_reg);
            nca_pkg::REG_DIMS:     prdata = nca_pkg::APB_DATA_WIDTH'(dims_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clusters_reg <= nca_pkg::CLUSTERS_RESET;
            dims_reg     <= nca_pkg::DIMS_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == nca_pkg::REG_CLUSTERS)
            begin
                clusters_reg <= pwdata[nca_pkg::CLUSTERS_WIDTH-1:0];
            end
            else
            begin
                dims_reg <= pwdata[nca_pkg::DIMS_WIDTH-1:0];
            end
        end
    end

    nca_front #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_DIMS     (MAX_DIMS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .active_clusters (clusters_reg),
        .active_dims     (dims_reg),
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .centroid_index  (centroid_index),
        .dim_index       (dim_index),
        .coord_value     (coord_value),
        .prev_cluster    (prev_cluster),
        .cmd_pop         (cmd_pop),
        .cmd_empty       (cmd_empty),
        .cmd             (cmd)
    );

    nca_back #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_DIMS     (MAX_DIMS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_word  (out_word)
    );

    nca_fifo #(
        .WIDTH (RES_W),
        .DEPTH (nca_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (RES_W'(out_word)),
        .full  (out_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_word        = nca_pkg::result_t'(res_rdata);
    assign best_cluster    = res_word.best_cluster;
    assign min_distance_sq = res_word.min_distance_sq;
    assign changed         = res_word.changed;

endmodule

`default_nettype wire

@@ tb/sv/nca_assignment_check.sv @@
// Watches the assigner's channels, predicts each nearest-centroid assignment and compares it.
`timescale 1ns / 1ps

module nca_assignment_check
    import nca_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [APB_ADDR_WIDTH-1:0]        paddr,
    input  logic [APB_DATA_WIDTH-1:0]        pwdata,
    input  logic                             push,
    input  logic                             full,
    input  logic                             req_type,
    input  logic [CIDX_WIDTH-1:0]            centroid_index,
    input  logic [DIDX_WIDTH-1:0]            dim_index,
    input  logic signed [FEATURE_WIDTH-1:0]  coord_value,
    input  logic [PREV_WIDTH-1:0]            prev_cluster,
    input  logic                             pop,
    input  logic                             empty,
    input  logic [BEST_WIDTH-1:0]            best_cluster,
    input  logic [DIST_WIDTH-1:0]            min_distance_sq,
    input  logic                             changed,
    output int                               mismatch_count,
    output int                               pending_results
);

    localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

    logic signed [FEATURE_WIDTH-1:0] centroid_mem [MAX_CLUSTERS][MAX_DIMS];
    logic [DIST_WIDTH-1:0]           dist_sum [MAX_CLUSTERS];
    logic [CLUSTERS_WIDTH-1:0]       clusters_reg = CLUSTERS_RESET;
    logic [DIMS_WIDTH-1:0]           dims_reg = DIMS_RESET;
    result_t                         awaited_assignments [$];
    int                              fails = 0;

    assign mismatch_count = fails;

    initial
    begin
        foreach (dist_sum[i])
        begin
            dist_sum[i] = '0;
        end
        foreach (centroid_mem[i, j])
        begin
            centroid_mem[i][j] = '0;
        end
    end

    task automatic fold_coordinate();
        int unsigned                     k;
        int unsigned                     d;
        int unsigned                     c;
        int unsigned                     best;
        logic signed [FEATURE_WIDTH:0]   diff;
        logic [FEATURE_WIDTH:0]          mag;
        logic [63:0]                     term;
        logic [63:0]                     total;
        logic [DIST_WIDTH-1:0]           best_d;
        result_t                         r;
        if (req_type == REQ_LOAD)
        begin
            if (32'(centroid_index) < MAX_CLUSTERS && 32'(dim_index) < MAX_DIMS)
            begin
                centroid_mem[centroid_index][dim_index] = coord_value;
            end
            return;
        end
        d = (dims_reg == '0) ? 1 : ((32'(dims_reg) > MAX_DIMS) ? MAX_DIMS : 32'(dims_reg));
        if (32'(dim_index) >= d)
        begin
            return;
        end
        k = (clusters_reg == '0) ? 1
            : ((32'(clusters_reg) > MAX_CLUSTERS) ? MAX_CLUSTERS : 32'(clusters_reg));
        for (c = 0; c < k; c++)
        begin
            diff = (FEATURE_WIDTH + 1)'(coord_value)
                   - (FEATURE_WIDTH + 1)'(centroid_mem[c][dim_index]);
            mag = (diff < 0) ? -diff : diff;
            term = 64'(mag) * 64'(mag);
            if (term > 64'(DIST_MAX))
            begin
                term = 64'(DIST_MAX);
            end
            total = 64'(dist_sum[c]) + term;
            dist_sum[c] = (total > 64'(DIST_MAX)) ? DIST_MAX : total[DIST_WIDTH-1:0];
        end
        if (32'(dim_index) != d - 1)
        begin
            return;
        end
        best = 0;
        best_d = dist_sum[0];
        for (c = 1; c < k; c++)
        begin
            if (dist_sum[c] < best_d)
            begin
                best_d = dist_sum[c];
                best = c;
            end
        end
        foreach (dist_sum[i])
        begin
            dist_sum[i] = '0;
        end
        r.best_cluster = best[BEST_WIDTH-1:0];
        r.min_distance_sq = best_d;
        r.changed = (32'(prev_cluster) != best);
        awaited_assignments.insert(awaited_assignments.size(), r);
    endtask

    task automatic match_assignment();
        result_t want;
        if (awaited_assignments.size() == 0)
        begin
            $error("unexpected word: best_cluster %0d min_distance_sq %0d changed %0d",
                   best_cluster, min_distance_sq, changed);
            fails++;
            return;
        end
        want = awaited_assignments.pop_front();
        if (best_cluster !== want.best_cluster)
        begin
            $error("best_cluster: expected %0d, got %0d", want.best_cluster, best_cluster);
            fails++;
        end
        if (min_distance_sq !== want.min_distance_sq)
        begin
            $error("min_distance_sq: expected %0d, got %0d",
                   want.min_distance_sq, min_distance_sq);
            fails++;
        end
        if (changed !== want.changed)
        begin
            $error("changed: expected %0d, got %0d", want.changed, changed);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == APB_ADDR_WIDTH'({REG_CLUSTERS, 2'b00}))
                begin
                    clusters_reg = pwdata[CLUSTERS_WIDTH-1:0];
                end
                else if (paddr == APB_ADDR_WIDTH'({REG_DIMS, 2'b00}))
                begin
                    dims_reg = pwdata[DIMS_WIDTH-1:0];
                end
            end
            if (push && !full)
            begin
                fold_coordinate();
            end
            if (pop && !empty)
            begin
                match_assignment();
            end
            pending_results <= awaited_assignments.size();
        end
    end

endmodule

@@ tb/sv/nearest_centroid_assigner_tb.sv @@
// Testbench top of the nearest-centroid assigner: clock, reset, register setup, stimulus, verdict.
`timescale 1ns / 1ps

module nearest_centroid_assigner_tb;
    import nca_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = (CMD_DEPTH + 1) * (MAX_CLUSTERS + 4) + 16;
    localparam int LIMIT_CYCLES    = 1_000_000;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [APB_ADDR_WIDTH-1:0]       paddr = '0;
    logic [APB_DATA_WIDTH-1:0]       pwdata = '0;
    logic [APB_DATA_WIDTH-1:0]       prdata;
    logic                            pready;
    logic                            push = 1'b0;
    logic                            full;
    logic                            req_type = REQ_LOAD;
    logic [CIDX_WIDTH-1:0]           centroid_index = '0;
    logic [DIDX_WIDTH-1:0]           dim_index = '0;
    logic signed [FEATURE_WIDTH-1:0] coord_value = '0;
    logic [PREV_WIDTH-1:0]           prev_cluster = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    logic [BEST_WIDTH-1:0]           best_cluster;
    logic [DIST_WIDTH-1:0]           min_distance_sq;
    logic                            changed;

    int mismatch_count;
    int pending_results;
    int cycle_count = 0;
    int burst_left = 0;
    int eff_k = int'(CLUSTERS_RESET);
    int eff_d = int'(DIMS_RESET);
    bit hold_off_req = 1'b0;
    bit draining = 1'b0;
    bit gaps_on = 1'b1;
    bit loaded [MAX_CLUSTERS][MAX_DIMS];

    nearest_centroid_assigner dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .centroid_index  (centroid_index),
        .dim_index       (dim_index),
        .coord_value     (coord_value),
        .prev_cluster    (prev_cluster),
        .empty           (empty),
        .pop             (pop),
        .best_cluster    (best_cluster),
        .min_distance_sq (min_distance_sq),
        .changed         (changed)
    );

    nca_assignment_check assign_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .centroid_index  (centroid_index),
        .dim_index       (dim_index),
        .coord_value     (coord_value),
        .prev_cluster    (prev_cluster),
        .pop             (pop),
        .empty           (empty),
        .best_cluster    (best_cluster),
        .min_distance_sq (min_distance_sq),
        .changed         (changed),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAIL nearest_centroid_assigner");
            $finish;
        end
    end

    initial
    begin
        int stall_pct;
        int stretch;
        stall_pct = 0;
        stretch = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            if (stretch == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    2: stall_pct = 70;
                    default: stall_pct = 95;
                endcase
                stretch = $urandom_range(20, 200);
            end
            stretch--;
            pop <= draining || ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic signed [FEATURE_WIDTH-1:0] rand_coord();
        logic signed [FEATURE_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'sh7FFF;
            1: v = 16'sh8000;
            2: v = '0;
            3: v = '1;
            default: v = FEATURE_WIDTH'($urandom());
        endcase
        return v;
    endfunction

    function automatic int rand_prev();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            return int'($urandom_range(0, eff_k - 1));
        end
        else if (r < 7)
        begin
            return MAX_CLUSTERS;
        end
        return int'($urandom_range(0, 127));
    endfunction

    task automatic send_word(input logic kind, input logic [CIDX_WIDTH-1:0] cidx,
                             input logic [DIDX_WIDTH-1:0] didx,
                             input logic signed [FEATURE_WIDTH-1:0] coord,
                             input logic [PREV_WIDTH-1:0] prev);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        push <= 1'b1;
        req_type <= kind;
        centroid_index <= cidx;
        dim_index <= didx;
        coord_value <= coord;
        prev_cluster <= prev;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic send_load(input int c, input int d, input logic signed [FEATURE_WIDTH-1:0] v);
        send_word(REQ_LOAD, CIDX_WIDTH'(c), DIDX_WIDTH'(d), v,
                  PREV_WIDTH'($urandom_range(0, 127)));
        loaded[c][d] = 1'b1;
    endtask

    task automatic send_point(input int d, input logic signed [FEATURE_WIDTH-1:0] v,
                              input int prev);
        send_word(REQ_POINT, CIDX_WIDTH'($urandom_range(0, 63)), DIDX_WIDTH'(d), v,
                  PREV_WIDTH'(prev));
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [APB_DATA_WIDTH-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_WIDTH'({reg_sel, 2'b00});
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic fill_store();
        for (int c = 0; c < eff_k; c++)
        begin
            for (int d = 0; d < eff_d; d++)
            begin
                if (!loaded[c][d])
                begin
                    send_load(c, d, rand_coord());
                end
            end
        end
    endtask

    task automatic set_config(input int raw_k, input int raw_d);
        logic [APB_DATA_WIDTH-1:0] w;
        wait_idle();
        w = $urandom();
        w[CLUSTERS_WIDTH-1:0] = CLUSTERS_WIDTH'(raw_k);
        apb_write(REG_CLUSTERS, w);
        w = $urandom();
        w[DIMS_WIDTH-1:0] = DIMS_WIDTH'(raw_d);
        apb_write(REG_DIMS, w);
        eff_k = (raw_k == 0) ? 1 : ((raw_k > MAX_CLUSTERS) ? MAX_CLUSTERS : raw_k);
        eff_d = (raw_d == 0) ? 1 : ((raw_d > MAX_DIMS) ? MAX_DIMS : raw_d);
        fill_store();
    endtask

    task automatic run_random(input int n_items);
        int sent;
        int kind;
        int stop;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                for (int j = 0; j < eff_d; j++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_load($urandom_range(0, MAX_CLUSTERS - 1),
                                  $urandom_range(0, MAX_DIMS - 1), rand_coord());
                        sent++;
                    end
                    send_point(j, rand_coord(), rand_prev());
                    sent++;
                end
            end
            else if (kind < 82)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_load($urandom_range(0, MAX_CLUSTERS - 1),
                              $urandom_range(0, MAX_DIMS - 1), rand_coord());
                    sent++;
                end
            end
            else if (kind < 92)
            begin
                send_point($urandom_range(0, MAX_DIMS - 1), rand_coord(), rand_prev());
                sent++;
            end
            else
            begin
                // drop the point partway; its partial sums carry into the next one
                stop = $urandom_range(0, eff_d - 1);
                for (int j = 0; j < stop; j++)
                begin
                    send_point(j, rand_coord(), rand_prev());
                end
                sent += stop;
            end
        end
    endtask

    task automatic run_directed();
        send_load(0, 0, 16'sh7FFF);
        send_load(0, 1, 16'sh8000);
        send_load(1, 0, 16'sh0000);
        send_load(1, 1, 16'sh0000);
        send_point(0, 16'sh8000, rand_prev());
        send_point(1, 16'sh7FFF, MAX_CLUSTERS);
        send_point(0, 16'sh0000, rand_prev());
        send_point(1, 16'sh0000, 1);
        send_point(15, 16'sh007B, rand_prev());
        send_load(1, 0, 16'sh7FFF);
        send_load(1, 1, 16'sh8000);
        send_point(0, 16'sh0001, rand_prev());
        send_point(1, 16'shFFFF, 0);
        send_point(1, 16'shFFFF, 127);
        send_point(0, 16'sh7FFF, rand_prev());
        send_point(0, 16'sh8000, rand_prev());
        send_load(0, 0, 16'shFFFF);
        send_point(1, 16'sh0000, 63);
        send_load(1, 0, 16'sh0000);
        send_load(1, 1, 16'sh0000);
        send_point(0, 16'sh5555, rand_prev());
        send_point(1, 16'shAAAA, 1);
        // drive both clusters into saturation so they tie at the ceiling
        send_load(0, 0, 16'sh7FFF);
        send_load(0, 1, 16'sh0000);
        send_load(1, 0, 16'sh8000);
        send_load(1, 1, 16'sh0000);
        for (int j = 0; j < 132; j++)
        begin
            send_point(0, (j % 2) ? 16'sh7FFF : 16'sh8000, rand_prev());
        end
        send_point(1, 16'sh0000, 0);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fill_store();
        run_random(40);
        set_config(2, 2);
        run_directed();
        set_config(1, 1);
        run_random(30);
        set_config(64, 2);
        run_random(60);
        set_config(0, 0);
        run_random(30);
        set_config(8, 2);
        gaps_on = 1'b0;
        hold_off_req = 1'b1;
        run_random(120);
        gaps_on = 1'b1;
        set_config(127, 3);
        run_random(30);
        repeat (3)
        begin
            set_config($urandom_range(1, 12), $urandom_range(1, 16));
            run_random(30);
        end
        set_config(3, 31);
        run_random(40);
        draining = 1'b1;
        wait_idle();
        if (mismatch_count == 0 && pending_results == 0)
        begin
            $display("PASS nearest_centroid_assigner");
        end
        else
        begin
            $display("FAIL nearest_centroid_assigner");
        end
        $finish;
    end

endmodule
